FILE: rtl/sdmc_pkg.sv
// Shared types and constants of the step detector with mean calibration.
`default_nettype none
package sdmc_pkg;

  localparam int ACCEL_W = 16;
  localparam int STEP_W  = 24;
  localparam int GAP_W   = 16;
  localparam int SUM_W   = 24;

  // Number of samples averaged into one set of thresholds.
  localparam int WINDOW  = 50;
  localparam int FILL_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;

  // Division by WINDOW is done as a multiplication by a rounded-up reciprocal.
  // With the shift set to the magnitude width plus log2 of the divisor, the
  // quotient is exact for every magnitude of SUM_W bits.
  localparam int              MEAN_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int              MULT_W     = SUM_W + 1;
  localparam longint unsigned MEAN_MULT  =
      ((longint'(1) << MEAN_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);

  localparam logic [STEP_W-1:0]  STEP_MAX = {STEP_W{1'b1}};
  localparam logic [FILL_W-1:0]  FILL_LAST = FILL_W'(WINDOW - 1);

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic [STEP_W-1:0]         step_total;
    logic                      in_step;
    logic                      detection_enabled;
    logic                      thresholds_updated;
    logic signed [ACCEL_W-1:0] threshold_x;
    logic signed [ACCEL_W-1:0] threshold_y;
    logic signed [ACCEL_W-1:0] threshold_z;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/sdmc_mean.sv
// Mean of one axis window sum: divide by WINDOW, truncate toward zero, saturate.
`default_nettype none
module sdmc_mean
  import sdmc_pkg::*;
(
  input  logic signed [SUM_W-1:0]   sum_i,
  output logic signed [ACCEL_W-1:0] mean_o
);

  localparam logic [MULT_W-1:0] MultK = MULT_W'(MEAN_MULT);
  localparam logic [SUM_W-1:0]  PosMax = SUM_W'(2 ** (ACCEL_W - 1) - 1);
  localparam logic [SUM_W-1:0]  NegMax = SUM_W'(2 ** (ACCEL_W - 1));

  logic                      neg;
  logic [SUM_W-1:0]          mag;
  logic [SUM_W+MULT_W-1:0]   prod;
  logic [SUM_W-1:0]          quot;
  logic [ACCEL_W-1:0]        quot_lo;

  always_comb begin
    neg     = sum_i[SUM_W-1];
    mag     = neg ? (SUM_W'(0) - SUM_W'(sum_i)) : SUM_W'(sum_i);
    prod    = (SUM_W+MULT_W)'(mag) * (SUM_W+MULT_W)'(MultK);
    quot    = SUM_W'(prod >> MEAN_SHIFT);
    quot_lo = quot[ACCEL_W-1:0];
    if (neg) begin
      if (quot >= NegMax) begin
        mean_o = {1'b1, {(ACCEL_W-1){1'b0}}};
      end else begin
        mean_o = ACCEL_W'(ACCEL_W'(0) - quot_lo);
      end
    end else begin
      if (quot > PosMax) begin
        mean_o = {1'b0, {(ACCEL_W-1){1'b1}}};
      end else begin
        mean_o = quot_lo;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/step_detector_with_mean_calibration_unit.sv
// Top level of the step detector with mean-threshold calibration.
//
// Usage:
// - The input channel (in_valid_i / in_ready_o / in_data_i) takes one
//   three-axis accelerometer sample per item, as signed raw counts.
// - The output channel (out_valid_o / out_ready_i / out_data_o) returns one
//   result item per sample: step count, in-step flag, detection enable,
//   a window-complete flag and the thresholds after the sample.
// - The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
//   the gap length. It is always ready; write it only while the block is idle.
// The result of an accepted sample is registered and presented, ready to be
// taken, in the cycle after. Throughput is one item per cycle while the
// receiver does not stall, set by the single result register; every sample
// is judged, summed unless a gap is running, and, at the end of a window,
// divided by three parallel reciprocal multipliers in the same cycle, so new
// thresholds are in place for the very next sample.
// When the receiver stalls, the result register holds and in_ready_o drops;
// it is high again in the cycle the held result is taken.
// Reset clears the thresholds, sums, counters, the step count, the in-step
// flag and the gap register, and empties the result register.
`default_nettype none
module step_detector_with_mean_calibration_unit
  import sdmc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sample_t          in_data_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_data_o,

  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [GAP_W-1:0] cfg_data_i
);

  // Calibration and detection state.
  logic signed [ACCEL_W-1:0] thr_x_q, thr_y_q, thr_z_q;
  logic signed [ACCEL_W-1:0] thr_x_d, thr_y_d, thr_z_d;
  logic signed [SUM_W-1:0]   acc_x_q, acc_y_q, acc_z_q;
  logic signed [SUM_W-1:0]   acc_x_d, acc_y_d, acc_z_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [GAP_W-1:0]          gap_left_q, gap_left_d;
  logic [GAP_W-1:0]          gap_cfg_q;
  logic [STEP_W-1:0]         steps_q, steps_d;
  logic                      phase_q, phase_d;

  // Result register.
  logic                      out_valid_q;
  result_t                   result_q, result_d;

  logic                      accept;
  logic                      enabled;
  logic                      all_above, all_below;
  logic                      add_step;
  logic                      window_done;
  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic signed [ACCEL_W-1:0] mean_x, mean_y, mean_z;

  // A new sample is taken whenever the result register is empty or is being
  // emptied in this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  // Window sums including the current sample.
  assign sum_x = acc_x_q + SUM_W'(in_data_i.accel_x);
  assign sum_y = acc_y_q + SUM_W'(in_data_i.accel_y);
  assign sum_z = acc_z_q + SUM_W'(in_data_i.accel_z);

  sdmc_mean u_mean_x (.sum_i(sum_x), .mean_o(mean_x));
  sdmc_mean u_mean_y (.sum_i(sum_y), .mean_o(mean_y));
  sdmc_mean u_mean_z (.sum_i(sum_z), .mean_o(mean_z));

  always_comb begin
    // Detection always uses the thresholds held before this sample.
    enabled   = (thr_x_q != '0) || (thr_y_q != '0) || (thr_z_q != '0);
    all_above = (in_data_i.accel_x > thr_x_q) && (in_data_i.accel_y > thr_y_q) &&
                (in_data_i.accel_z > thr_z_q);
    all_below = (in_data_i.accel_x < thr_x_q) && (in_data_i.accel_y < thr_y_q) &&
                (in_data_i.accel_z < thr_z_q);

    phase_d  = phase_q;
    add_step = 1'b0;
    if (enabled) begin
      if (all_above) begin
        add_step = 1'b1;
        phase_d  = 1'b1;
      end else if (all_below && phase_q) begin
        add_step = 1'b1;
        phase_d  = 1'b0;
      end
    end
    steps_d = (add_step && (steps_q != STEP_MAX)) ? steps_q + STEP_W'(1) : steps_q;

    // Calibration: skip gap samples, else sum and reload thresholds when full.
    thr_x_d     = thr_x_q;
    thr_y_d     = thr_y_q;
    thr_z_d     = thr_z_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    acc_z_d     = acc_z_q;
    fill_d      = fill_q;
    gap_left_d  = gap_left_q;
    window_done = 1'b0;
    if (gap_left_q != '0) begin
      gap_left_d = gap_left_q - GAP_W'(1);
    end else if (fill_q == FILL_LAST) begin
      window_done = 1'b1;
      thr_x_d     = mean_x;
      thr_y_d     = mean_y;
      thr_z_d     = mean_z;
      acc_x_d     = '0;
      acc_y_d     = '0;
      acc_z_d     = '0;
      fill_d      = '0;
      gap_left_d  = gap_cfg_q;
    end else begin
      acc_x_d = sum_x;
      acc_y_d = sum_y;
      acc_z_d = sum_z;
      fill_d  = fill_q + FILL_W'(1);
    end

    result_d.step_total         = steps_d;
    result_d.in_step            = phase_d;
    result_d.detection_enabled  = enabled;
    result_d.thresholds_updated = window_done;
    result_d.threshold_x        = thr_x_d;
    result_d.threshold_y        = thr_y_d;
    result_d.threshold_z        = thr_z_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_x_q     <= '0;
      thr_y_q     <= '0;
      thr_z_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
      fill_q      <= '0;
      gap_left_q  <= '0;
      gap_cfg_q   <= '0;
      steps_q     <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gap_cfg_q <= cfg_data_i;
      end
      if (accept) begin
        thr_x_q    <= thr_x_d;
        thr_y_q    <= thr_y_d;
        thr_z_q    <= thr_z_d;
        acc_x_q    <= acc_x_d;
        acc_y_q    <= acc_y_d;
        acc_z_q    <= acc_z_d;
        fill_q     <= fill_d;
        gap_left_q <= gap_left_d;
        steps_q    <= steps_d;
        phase_q    <= phase_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the step detector with mean-threshold calibration.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import sdmc_pkg::*;

  // Cycles without any handshake after which the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold-off below.
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 330;
  localparam int NUM_PHASES  = 6;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready_o;
  sample_t          in_data = '0;

  logic             out_valid_o;
  logic             out_ready = 1'b0;
  result_t          out_data_o;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  logic [GAP_W-1:0] cfg_data = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  step_detector_with_mean_calibration_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // Samples waiting to be offered, and the results that accepted samples owe.
  sample_t pending_samples[$];
  result_t results_due[$];
  int      mismatch_count = 0;

  // Idle percentages of both sides, set per phase by the stimulus process.
  int      send_idle_pct = 12;
  int      recv_idle_pct = 84;

  // The stimulus process arms one long receiver hold-off; its own counter runs it.
  bit      hold_armed = 1'b0;

  // Shadow state of the detector and its calibration.
  logic signed [ACCEL_W-1:0] thr_x, thr_y, thr_z;
  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [7:0]                fill_count;
  logic [GAP_W-1:0]          gap_count;
  logic [GAP_W-1:0]          gap_setting;
  logic [STEP_W-1:0]         step_tally;
  logic                      stepping;

  initial begin
    thr_x = '0; thr_y = '0; thr_z = '0;
    sum_x = '0; sum_y = '0; sum_z = '0;
    fill_count  = '0;
    gap_count   = '0;
    gap_setting = '0;
    step_tally  = '0;
    stepping    = 1'b0;
  end

  // Mean of a window sum, truncated toward zero and kept in threshold range.
  function automatic logic signed [ACCEL_W-1:0] window_mean(logic signed [SUM_W-1:0] total);
    longint q;
    q = longint'(total) / longint'(WINDOW);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[ACCEL_W-1:0];
  endfunction

  // Judges one sample against the thresholds held before it, then feeds the
  // calibration, and returns the result item the block must produce.
  function automatic result_t detect_and_calibrate(sample_t s);
    result_t r;
    logic    enabled;
    logic    reloaded;
    enabled  = (thr_x != 0) || (thr_y != 0) || (thr_z != 0);
    reloaded = 1'b0;

    if (enabled) begin
      if (s.accel_x > thr_x && s.accel_y > thr_y && s.accel_z > thr_z) begin
        if (step_tally != STEP_MAX) step_tally = step_tally + 1'b1;
        stepping = 1'b1;
      end else if (s.accel_x < thr_x && s.accel_y < thr_y && s.accel_z < thr_z) begin
        if (stepping) begin
          if (step_tally != STEP_MAX) step_tally = step_tally + 1'b1;
          stepping = 1'b0;
        end
      end
    end

    // A running gap skips calibration; otherwise the sample is summed and a
    // full window reloads the thresholds and starts the next gap.
    if (gap_count != 0) begin
      gap_count = gap_count - 1'b1;
    end else begin
      sum_x = sum_x + s.accel_x;
      sum_y = sum_y + s.accel_y;
      sum_z = sum_z + s.accel_z;
      fill_count = fill_count + 1'b1;
      if (fill_count >= WINDOW) begin
        thr_x = window_mean(sum_x);
        thr_y = window_mean(sum_y);
        thr_z = window_mean(sum_z);
        sum_x = '0; sum_y = '0; sum_z = '0;
        fill_count = '0;
        gap_count  = gap_setting;
        reloaded   = 1'b1;
      end
    end

    r.step_total         = step_tally;
    r.in_step            = stepping;
    r.detection_enabled  = enabled;
    r.thresholds_updated = reloaded;
    r.threshold_x        = thr_x;
    r.threshold_y        = thr_y;
    r.threshold_z        = thr_z;
    return r;
  endfunction

  // Driver: records the prediction of each accepted sample and offers the
  // next one once the current item is gone. Valid stays up until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        results_due.push_back(detect_and_calibrate(in_data));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Long hold-off of the receiver, counted in cycles. It lets the block fill
  // up and stall its input while the driver keeps offering samples.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // decides the receiver's ready for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected item", longint'(out_data_o.step_total), 0);
        end else begin
          want = results_due.pop_front();
          if (out_data_o.step_total !== want.step_total)
            report_mismatch("step_total", longint'(out_data_o.step_total),
                            longint'(want.step_total));
          if (out_data_o.in_step !== want.in_step)
            report_mismatch("in_step", longint'(out_data_o.in_step),
                            longint'(want.in_step));
          if (out_data_o.detection_enabled !== want.detection_enabled)
            report_mismatch("detection_enabled", longint'(out_data_o.detection_enabled),
                            longint'(want.detection_enabled));
          if (out_data_o.thresholds_updated !== want.thresholds_updated)
            report_mismatch("thresholds_updated", longint'(out_data_o.thresholds_updated),
                            longint'(want.thresholds_updated));
          if (out_data_o.threshold_x !== want.threshold_x)
            report_mismatch("threshold_x", longint'(out_data_o.threshold_x),
                            longint'(want.threshold_x));
          if (out_data_o.threshold_y !== want.threshold_y)
            report_mismatch("threshold_y", longint'(out_data_o.threshold_y),
                            longint'(want.threshold_y));
          if (out_data_o.threshold_z !== want.threshold_z)
            report_mismatch("threshold_z", longint'(out_data_o.threshold_z),
                            longint'(want.threshold_z));
        end
      end

      if (hold_left != 0 || (hold_armed && !hold_done)) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake restarts the count of quiet cycles.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes the gap register through its channel; the shadow copy follows
  // at the accepting edge.
  task automatic write_gap(logic [GAP_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gap_setting = value;
    cfg_valid <= 1'b0;
  endtask

  // Returns to the falling edge once every sample is out and answered.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  // One axis value strictly above (up) or below the threshold, mostly close
  // to it, sometimes anywhere in range. At the range limit it stays equal.
  function automatic logic signed [ACCEL_W-1:0] axis_value(logic signed [ACCEL_W-1:0] t,
                                                           bit up);
    int span;
    int off;
    span = up ? (32767 - int'(t)) : (int'(t) + 32768);
    if (span == 0) return t;
    if ($urandom_range(0, 1)) off = $urandom_range(1, (span < 300) ? span : 300);
    else off = $urandom_range(1, span);
    return up ? ACCEL_W'(int'(t) + off) : ACCEL_W'(int'(t) - off);
  endfunction

  // Mostly samples that clear or undercut all thresholds, so steps keep
  // coming; some touch a threshold exactly on one axis, the rest are noise.
  function automatic sample_t random_sample();
    sample_t s;
    int      kind;
    int      axis;
    kind = $urandom_range(0, 99);
    if (kind < 38) begin
      s.accel_x = axis_value(thr_x, 1);
      s.accel_y = axis_value(thr_y, 1);
      s.accel_z = axis_value(thr_z, 1);
    end else if (kind < 76) begin
      s.accel_x = axis_value(thr_x, 0);
      s.accel_y = axis_value(thr_y, 0);
      s.accel_z = axis_value(thr_z, 0);
    end else if (kind < 86) begin
      bit up;
      up   = $urandom_range(0, 1);
      axis = $urandom_range(0, 2);
      s.accel_x = (axis == 0) ? thr_x : axis_value(thr_x, up);
      s.accel_y = (axis == 1) ? thr_y : axis_value(thr_y, up);
      s.accel_z = (axis == 2) ? thr_z : axis_value(thr_z, up);
    end else begin
      s.accel_x = ACCEL_W'($urandom);
      s.accel_y = ACCEL_W'($urandom);
      s.accel_z = ACCEL_W'($urandom);
    end
    return s;
  endfunction

  // Stimulus: reset, a directed set of extreme samples, then random phases
  // that step through gap settings and idle patterns.
  initial begin
    sample_t          corner;
    logic [GAP_W-1:0] phase_gap[NUM_PHASES];
    int               corners[6];

    corners = '{32767, -32768, 0, -1, 1, 21845};
    phase_gap[0] = 16'd5;
    phase_gap[1] = 16'd1;
    phase_gap[2] = GAP_W'($urandom_range(0, 200));
    phase_gap[3] = 16'd40;
    phase_gap[4] = 16'd0;
    phase_gap[5] = 16'hFFFF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_gap('0);

    // Field extremes and bit patterns while detection is still off.
    @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      corner.accel_x = ACCEL_W'(corners[i]);
      corner.accel_y = ACCEL_W'(corners[i]);
      corner.accel_z = ACCEL_W'(corners[i]);
      pending_samples.push_back(corner);
      corner.accel_x = ACCEL_W'(corners[(i + 1) % 6]);
      corner.accel_y = ACCEL_W'(corners[(i + 3) % 6]);
      corner.accel_z = ACCEL_W'(corners[(i + 5) % 6]);
      pending_samples.push_back(corner);
      corner.accel_x = ~corner.accel_x;
      corner.accel_y = ~corner.accel_y;
      corner.accel_z = ~corner.accel_z;
      pending_samples.push_back(corner);
    end
    // The sender pauses here until every result has come back.
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Gap changes land between phases, often in the middle of a gap.
      write_gap(phase_gap[p]);
      @(negedge clk_i);
      if (p < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 84;
      end else if (p < 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) hold_armed = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (pending_samples.size() >= 4) @(negedge clk_i);
        pending_samples.push_back(random_sample());
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
